FILE: sv/smx_pkg.sv
// smx_pkg: shared types, constants and the 2^-f table for the softmax unit
// no dependencies
`timescale 1ns / 1ps
package smx_pkg;

  localparam logic [15:0] LOG2E_Q15 = 16'd47274;
  localparam logic signed [15:0] MAX_RESET = 16'sh8000;

  typedef struct packed {
    logic store;
    logic ld_t;
    logic ld_prod;
    logic ld_e;
    logic acc;
    logic clr_sum;
    logic div_init;
    logic div_step;
    logic k_inc;
    logic k_clr;
    logic clr_vec;
  } smx_cmd_t;

  typedef struct packed {
    logic k_last;
    logic div_done;
    logic full;
  } smx_status_t;

  function automatic logic [16:0] pow2_frac(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0: v = 17'd65536;
      5'd1: v = 17'd62757;
      5'd2: v = 17'd60097;
      5'd3: v = 17'd57549;
      5'd4: v = 17'd55109;
      5'd5: v = 17'd52773;
      5'd6: v = 17'd50535;
      5'd7: v = 17'd48393;
      5'd8: v = 17'd46341;
      5'd9: v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/smx_ram.sv
// smx_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module smx_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/smx_ctrl.sv
// smx_ctrl: sequencer for store, exp sum pass and divide pass
// depends on smx_pkg
`timescale 1ns / 1ps
module smx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                last_element,
  input  smx_pkg::smx_status_t status,
  output smx_pkg::smx_cmd_t   cmd,
  output logic                busy,
  output logic                strobe
);
  import smx_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_INT   = 4'd3;
  localparam logic [3:0] S_EXP   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state, state_next;
  logic       pass2, pass2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass2 <= 1'b0;
    end else begin
      state <= state_next;
      pass2 <= pass2_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    pass2_next = pass2;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.store = ~status.full;
          if (last_element) begin
            cmd.clr_sum = 1'b1;
            cmd.k_clr = 1'b1;
            pass2_next = 1'b0;
            state_next = S_RD;
          end
        end
      end
      S_RD: state_next = S_MUL;
      S_MUL: begin
        cmd.ld_t = 1'b1;
        state_next = S_INT;
      end
      S_INT: begin
        cmd.ld_prod = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.ld_e = 1'b1;
        state_next = pass2 ? S_DINIT : S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (status.k_last) begin
          cmd.k_clr = 1'b1;
          pass2_next = 1'b1;
        end else begin
          cmd.k_inc = 1'b1;
        end
        state_next = S_RD;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.k_last) begin
          cmd.clr_vec = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign strobe = (state == S_OUT);

endmodule

FILE: sv/smx_datapath.sv
// smx_datapath: element store, running max, fixed-point exp, sum and divider
// depends on smx_pkg and smx_ram
`timescale 1ns / 1ps
module smx_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic signed [15:0]   logit,
  input  smx_pkg::smx_cmd_t    cmd,
  output smx_pkg::smx_status_t status,
  output logic [15:0]          probability,
  output logic                 last_result
);
  import smx_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] LEN_C = CW'(MAX_LEN);

  logic [CW-1:0]      count;
  logic signed [15:0] running_max;
  logic [AW-1:0]      k;
  logic [22:0]        exp_sum;
  logic [31:0]        t;
  logic [16:0]        hi;
  logic [8:0]         n;
  logic [30:0]        prod;
  logic [16:0]        e;
  logic [22:0]        rem;
  logic [32:0]        num;
  logic [32:0]        q;
  logic [5:0]         dcnt;
  logic [15:0]        rdata;

  logic [15:0] diff;
  logic [16:0] lo;
  logic [16:0] hi_c;
  logic [16:0] m;
  logic [23:0] rem_sh;
  logic        qbit;

  smx_ram #(.WIDTH(16), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count[AW-1:0]),
    .wdata (logit),
    .raddr (k),
    .rdata (rdata)
  );

  assign diff = 16'(running_max - $signed(rdata));
  assign hi_c = pow2_frac({1'b0, t[22:19]});
  assign lo = pow2_frac(5'({1'b0, t[22:19]}) + 5'd1);
  assign m = hi - {5'd0, prod[30:19]};
  assign rem_sh = {rem, num[32]};
  assign qbit = (rem_sh >= {1'b0, exp_sum});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      running_max <= MAX_RESET;
      exp_sum <= '0;
      k <= '0;
      dcnt <= '0;
    end else begin
      if (cmd.store) begin
        count <= count + CW'(1);
        if (logit > running_max) begin
          running_max <= logit;
        end
      end
      if (cmd.clr_vec) begin
        count <= '0;
        running_max <= MAX_RESET;
        exp_sum <= '0;
      end
      if (cmd.clr_sum) begin
        exp_sum <= '0;
      end
      if (cmd.acc) begin
        exp_sum <= exp_sum + {6'd0, e};
      end
      if (cmd.k_clr) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + AW'(1);
      end
      if (cmd.div_init) begin
        dcnt <= '0;
      end else if (cmd.div_step) begin
        dcnt <= dcnt + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_t) begin
      t <= 32'(diff) * 32'(LOG2E_Q15);
    end
    if (cmd.ld_prod) begin
      hi <= hi_c;
      n <= t[31:23];
      prod <= 31'(12'(hi_c - lo)) * 31'(t[18:0]);
    end
    if (cmd.ld_e) begin
      e <= (n >= 9'd17) ? 17'd0 : (m >> n);
    end
    if (cmd.div_init) begin
      num <= {e, 16'd0} + {11'd0, exp_sum[22:1]};
      rem <= '0;
      q <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? 23'(rem_sh - {1'b0, exp_sum}) : rem_sh[22:0];
      num <= {num[31:0], 1'b0};
      q <= {q[31:0], qbit};
    end
  end

  assign status.k_last = ({{(CW-AW){1'b0}}, k} == count - CW'(1));
  assign status.div_done = (dcnt == 6'd32);
  assign status.full = (count >= LEN_C);

  assign probability = (|q[32:16]) ? 16'hFFFF : q[15:0];
  assign last_result = status.k_last;

endmodule

FILE: sv/softmax_vector_unit.sv
// softmax_vector_unit: top level, controller plus datapath
// depends on smx_pkg, smx_ctrl and smx_datapath
`timescale 1ns / 1ps
// Logits arrive one per transaction and each takes a single cycle; busy stays
// low while a vector is being loaded. The transaction that carries
// last_element starts the computation: a sum pass over the stored elements
// (ram read, two multiplies, shift, accumulate for each), then for each element
// an exp recompute, a one-bit-per-cycle 33 step divider and an output state
// that shows the probability with strobe high. A vector keeps busy high
// through both passes. The receiver cannot stall, so every strobe must be
// taken. Elements beyond MAX_LEN are dropped.
module softmax_vector_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] logit,
  input  logic               last_element,
  output logic               strobe,
  output logic [15:0]        probability,
  output logic               last_result
);
  import smx_pkg::*;

  smx_cmd_t    cmd;
  smx_status_t status;

  smx_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_element (last_element),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .strobe       (strobe)
  );

  smx_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .logit       (logit),
    .cmd         (cmd),
    .status      (status),
    .probability (probability),
    .last_result (last_result)
  );

endmodule

FILE: sv/smx_checker.sv
// smx_checker: port level assertions for softmax_vector_unit
// bound to the top level, no other dependencies
`timescale 1ns / 1ps
module smx_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last_result
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result without busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last_result |=> !busy)
    else $error("busy after last result");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("not idle after reset");

endmodule

bind softmax_vector_unit smx_checker u_smx_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .last_result (last_result)
);

FILE: test/tb_softmax_vector_unit.sv
// tb_softmax_vector_unit: self-checking testbench for the softmax vector unit
// depends on smx_pkg and softmax_vector_unit; predicts each probability from the
// logits sent and compares every strobed transaction in order
`timescale 1ns / 1ps
module tb_softmax_vector_unit;
  import smx_pkg::*;

  localparam int VEC_MAX = 64;

  typedef struct {
    logic [15:0] probability;
    logic        last_result;
  } prob_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] logit;
  logic               last_element;
  logic               strobe;
  logic [15:0]        probability;
  logic               last_result;

  prob_t       expected_probs[$];
  logic signed [15:0] vec_store[VEC_MAX];
  int          vec_count;
  logic signed [15:0] vec_max;
  int          mismatches;
  int          burst_left;

  softmax_vector_unit #(.MAX_LEN(VEC_MAX)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .logit(logit),
    .last_element(last_element), .strobe(strobe), .probability(probability),
    .last_result(last_result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [16:0] frac_entry(input int i);
    case (i)
      0: return 17'd65536;
      1: return 17'd62757;
      2: return 17'd60097;
      3: return 17'd57549;
      4: return 17'd55109;
      5: return 17'd52773;
      6: return 17'd50535;
      7: return 17'd48393;
      8: return 17'd46341;
      9: return 17'd44376;
      10: return 17'd42495;
      11: return 17'd40693;
      12: return 17'd38968;
      13: return 17'd37316;
      14: return 17'd35734;
      15: return 17'd34219;
      default: return 17'd32768;
    endcase
  endfunction

  function automatic logic [31:0] scaled_exp(input logic signed [15:0] x,
                                             input logic signed [15:0] mx);
    logic [15:0] diff;
    logic [63:0] t;
    logic [31:0] n;
    logic [22:0] f;
    logic [18:0] r;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] m;
    diff = mx - x;
    t = 64'(diff) * 64'(LOG2E_Q15);
    n = 32'(t >> 23);
    f = t[22:0];
    r = f[18:0];
    hi = 32'(frac_entry(int'(f[22:19])));
    lo = 32'(frac_entry(int'(f[22:19]) + 1));
    m = 64'(hi) - ((64'(hi - lo) * 64'(r)) >> 19);
    if (n >= 32) return 32'd0;
    return 32'(m >> n);
  endfunction

  task automatic predict_logit(input logic signed [15:0] x, input logic lst);
    logic [31:0] e[VEC_MAX];
    logic [22:0] total;
    logic [63:0] q;
    prob_t       p;
    if (vec_count < VEC_MAX) begin
      vec_store[vec_count] = x;
      vec_count++;
      if (x > vec_max) vec_max = x;
    end
    if (!lst) return;
    total = '0;
    for (int k = 0; k < vec_count; k++) begin
      e[k] = scaled_exp(vec_store[k], vec_max);
      total = total + 23'(e[k]);
    end
    for (int k = 0; k < vec_count; k++) begin
      q = 0;
      if (total != 0) q = ((64'(e[k]) << 16) + 64'(total >> 1)) / 64'(total);
      if (q > 65535) q = 65535;
      p.probability = q[15:0];
      p.last_result = (k + 1 == vec_count);
      expected_probs.push_back(p);
    end
    vec_count = 0;
    vec_max = MAX_RESET;
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // one transaction; the sender idles in random bursts and gaps
  task automatic send_logit(input logic signed [15:0] x, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    logit <= x;
    last_element <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_logit(x, lst);
  endtask

  task automatic wait_drained;
    start <= 1'b0;
    while (expected_probs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    prob_t p;
    if (!rst && strobe) begin
      if (expected_probs.size() == 0) begin
        report_mismatch("unexpected result");
      end else begin
        p = expected_probs.pop_front();
        if (probability !== p.probability)
          report_mismatch($sformatf("probability %0d, expected %0d", probability,
                                    p.probability));
        if (last_result !== p.last_result)
          report_mismatch($sformatf("last_result %0b, expected %0b", last_result,
                                    p.last_result));
      end
    end
  end

  task automatic test_extremes;
    send_logit(16'sh7fff, 1'b0);
    send_logit(16'sh8000, 1'b1);
    send_logit(16'sh0000, 1'b0);
    send_logit(16'sh0000, 1'b1);
    send_logit(16'sh8000, 1'b0);
    send_logit(16'sh8000, 1'b1);
    send_logit(16'shffff, 1'b0);
    send_logit(16'sh0100, 1'b0);
    send_logit(16'sh5555, 1'b0);
    send_logit(16'shaaaa, 1'b1);
  endtask

  task automatic test_single_element;
    send_logit(16'sh1234, 1'b1);
    send_logit(16'sh8000, 1'b1);
  endtask

  // store full: extra elements dropped, flag still ends the vector
  task automatic test_store_full;
    for (int k = 0; k < VEC_MAX + 3; k++)
      send_logit(k == VEC_MAX + 1 ? 16'sh7fff : 16'($urandom_range(0, 1023)),
                 k == VEC_MAX + 2);
  endtask

  task automatic test_random_vectors;
    int sent;
    int len;
    sent = 0;
    while (sent < 280) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_logit(16'($urandom), k == len - 1);
        else
          send_logit(16'($signed(16'($urandom_range(0, 4095))) - 16'sd2048),
                     k == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 7) == 0) wait_drained;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    logit = '0;
    last_element = 1'b0;
    mismatches = 0;
    vec_count = 0;
    vec_max = MAX_RESET;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes;
    test_single_element;
    wait_drained;
    test_store_full;
    test_random_vectors;
    wait_drained;
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_probs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
